FILE: rtl/vxrp_pkg.sv
// shared constants and sine table builder for the vertex rotate and project block
`default_nettype none

package vxrp_pkg;

    localparam int COORD_BITS_DEF = 14;
    localparam int ANGLE_BITS_DEF = 10;

    localparam int FRAC_BITS    = 8;
    localparam int TRIG_FRAC    = 14;
    localparam int TRIG_BITS    = 16;
    localparam int OFFSET_BITS  = 10;
    localparam int OFFSET_RESET = 200;
    localparam int ADDR_BITS    = 3;
    localparam int DATA_BITS    = 32;

    localparam logic REG_ANGLE  = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // ceil(2^64 / d) for the series divisors (2n)(2n+1)
    localparam logic [127:0] RECIP_BASE = 128'd1 << 64;
    localparam logic [127:0] RECIP_6    = (RECIP_BASE + 128'd5) / 128'd6;
    localparam logic [127:0] RECIP_20   = (RECIP_BASE + 128'd19) / 128'd20;
    localparam logic [127:0] RECIP_42   = (RECIP_BASE + 128'd41) / 128'd42;
    localparam logic [127:0] RECIP_72   = (RECIP_BASE + 128'd71) / 128'd72;
    localparam logic [127:0] RECIP_110  = (RECIP_BASE + 128'd109) / 128'd110;
    localparam logic [127:0] RECIP_156  = (RECIP_BASE + 128'd155) / 128'd156;
    localparam logic [127:0] RECIP_210  = (RECIP_BASE + 128'd209) / 128'd210;
    localparam logic [127:0] RECIP_272  = (RECIP_BASE + 128'd271) / 128'd272;
    localparam logic [127:0] RECIP_342  = (RECIP_BASE + 128'd341) / 128'd342;
    localparam logic [127:0] RECIP_420  = (RECIP_BASE + 128'd419) / 128'd420;

    function automatic logic [127:0] recip_of(input int n);
        case (n)
            1:       return RECIP_6;
            2:       return RECIP_20;
            3:       return RECIP_42;
            4:       return RECIP_72;
            5:       return RECIP_110;
            6:       return RECIP_156;
            7:       return RECIP_210;
            8:       return RECIP_272;
            9:       return RECIP_342;
            10:      return RECIP_420;
            default: return RECIP_BASE;
        endcase
    endfunction

    // quarter-wave entry in q1.14, taylor series in unsigned q30
    function automatic logic [TRIG_BITS-2:0] sine_entry(input int idx, input int angle_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        q;
        logic [127:0]       prod;
        logic signed [63:0] sum;
        int                 n;
        x    = (PI_Q30 * 64'(idx)) >> (angle_bits - 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (n = 1; n <= 10; n++)
        begin
            // quotient by reciprocal, exact for dividends below 2^34
            q    = (term * x2) >> 30;
            prod = {64'd0, q} * recip_of(n);
            term = prod[127:64];
            if (n[0])
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        return (TRIG_BITS - 1)'(($unsigned(sum) + 64'd32768) >> 16);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/vertex_xzy_rotate_project.sv
// vertex rotate about x, z, y with orthographic projection, pipelined top level
//
// usage:
//   a vertex beat (vertex_x, vertex_y, vertex_z) is taken at a rising edge with
//   start high and busy low; busy stays low, so one vertex enters every cycle
//   each vertex gives one result beat: screen_x and screen_y with done high for
//   exactly one cycle, after the vertex has passed every register stage below
//   throughput is one vertex per cycle; the pipeline has eight register
//   stages: input, three multiply stages and three rounding stages interleaved,
//   and the output stage
//   rotation_angle (offset 0x0) and screen_offset (offset 0x4) sit on the apb
//   port; write them only while no vertex is in flight
//   reset clears the pipeline valid bits, sets rotation_angle to 0 and
//   screen_offset to 200
//   the receiver cannot stall: a result beat is present for one cycle only
`default_nettype none

module vertex_xzy_rotate_project #(
    parameter int COORD_BITS = vxrp_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = vxrp_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [COORD_BITS-1:0]        vertex_x,
    input  wire logic signed [COORD_BITS-1:0]        vertex_y,
    input  wire logic signed [COORD_BITS-1:0]        vertex_z,
    output logic                                     done,
    output logic signed [COORD_BITS:0]               screen_x,
    output logic signed [COORD_BITS:0]               screen_y,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [vxrp_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [vxrp_pkg::DATA_BITS-1:0]      pwdata,
    output logic [vxrp_pkg::DATA_BITS-1:0]           prdata,
    output logic                                     pready
);

    import vxrp_pkg::*;

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int W       = COORD_BITS + FRAC_BITS + 2;
    localparam int PW      = W + TRIG_BITS;
    localparam int SW      = PW + 1;
    localparam int OW      = W + 1;
    localparam int QW      = OW - FRAC_BITS;
    localparam int LATENCY = 8;

    localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (TRIG_FRAC - 1);
    localparam logic signed [QW-1:0] OUT_MAX  = (QW'(1) <<< COORD_BITS) - QW'(1);
    localparam logic signed [QW-1:0] OUT_MIN  = -(QW'(1) <<< COORD_BITS);
    localparam logic signed [TRIG_BITS-1:0] TRIG_ONE = TRIG_BITS'(1) <<< TRIG_FRAC;

    typedef logic signed [W-1:0]  coord_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [TRIG_BITS-1:0] trig_t;

    // sine table
    logic [TRIG_BITS-2:0] sine_rom [QUARTER+1];

    for (genvar gi = 0; gi <= QUARTER; gi++)
    begin : g_rom
        localparam logic [TRIG_BITS-2:0] SINE_VAL = sine_entry(gi, ANGLE_BITS);
        assign sine_rom[gi] = SINE_VAL;
    end

    function automatic trig_t trig_of(input logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS-3:0] r;
        logic [ANGLE_BITS-2:0] idx;
        trig_t                 v;
        r   = a[ANGLE_BITS-3:0];
        idx = a[ANGLE_BITS-2] ? ((ANGLE_BITS - 1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
        v   = $signed({1'b0, sine_rom[idx]});
        return a[ANGLE_BITS-1] ? -v : v;
    endfunction

    function automatic coord_t rnd(input logic signed [SW-1:0] p);
        logic signed [SW-1:0] t;
        t = p + RND_HALF;
        return W'(t >>> TRIG_FRAC);
    endfunction

    function automatic logic signed [COORD_BITS:0] trunc_sat(input logic signed [OW-1:0] v);
        logic signed [QW-1:0] q;
        q = QW'(v >>> FRAC_BITS);
        if (v[OW-1] && (v[FRAC_BITS-1:0] != '0))
        begin
            q = q + QW'(1);
        end
        if (q > OUT_MAX)
        begin
            q = OUT_MAX;
        end
        else if (q < OUT_MIN)
        begin
            q = OUT_MIN;
        end
        return (COORD_BITS + 1)'(q);
    endfunction

    // configuration port
    logic [ANGLE_BITS-1:0]  angle_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg  <= '0;
            offset_reg <= OFFSET_BITS'(OFFSET_RESET);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_ANGLE:  angle_reg  <= pwdata[ANGLE_BITS-1:0];
                REG_OFFSET: offset_reg <= pwdata[OFFSET_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ANGLE:  prdata = DATA_BITS'(angle_reg);
            REG_OFFSET: prdata = DATA_BITS'(offset_reg);
            default:    prdata = '0;
        endcase
    end

    // sine and cosine of the configured angle
    trig_t sin_reg;
    trig_t cos_reg;
    trig_t sin_next;
    trig_t cos_next;

    assign sin_next = trig_of(angle_reg);
    assign cos_next = trig_of(angle_reg + ANGLE_BITS'(QUARTER));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg <= '0;
            cos_reg <= TRIG_ONE;
        end
        else
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    // pipeline
    logic                accept;
    logic [LATENCY-1:0]  valid_reg;

    coord_t x0_reg, y0_reg, z0_reg;
    prod_t  pa1_reg, pb1_reg, pc1_reg, pd1_reg;
    coord_t x1_reg;
    coord_t x2_reg, y2_reg, z2_reg;
    prod_t  pa3_reg, pb3_reg, pc3_reg, pd3_reg;
    coord_t z3_reg;
    coord_t x4_reg, y4_reg, z4_reg;
    prod_t  pa5_reg, pb5_reg;
    coord_t y5_reg;
    coord_t x6_reg, y6_reg;
    logic signed [OW-1:0] off_q8;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign off_q8 = $signed({{(OW - OFFSET_BITS - FRAC_BITS){1'b0}}, offset_reg,
                             {FRAC_BITS{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        // input, to q8
        x0_reg  <= W'(vertex_x) <<< FRAC_BITS;
        y0_reg  <= W'(vertex_y) <<< FRAC_BITS;
        z0_reg  <= W'(vertex_z) <<< FRAC_BITS;
        // about x
        pa1_reg <= PW'(cos_reg) * PW'(y0_reg);
        pb1_reg <= PW'(sin_reg) * PW'(z0_reg);
        pc1_reg <= PW'(sin_reg) * PW'(y0_reg);
        pd1_reg <= PW'(cos_reg) * PW'(z0_reg);
        x1_reg  <= x0_reg;
        y2_reg  <= rnd(SW'(pa1_reg) - SW'(pb1_reg));
        z2_reg  <= rnd(SW'(pc1_reg) + SW'(pd1_reg));
        x2_reg  <= x1_reg;
        // about z
        pa3_reg <= PW'(cos_reg) * PW'(x2_reg);
        pb3_reg <= PW'(sin_reg) * PW'(y2_reg);
        pc3_reg <= PW'(sin_reg) * PW'(x2_reg);
        pd3_reg <= PW'(cos_reg) * PW'(y2_reg);
        z3_reg  <= z2_reg;
        x4_reg  <= rnd(SW'(pa3_reg) - SW'(pb3_reg));
        y4_reg  <= rnd(SW'(pc3_reg) + SW'(pd3_reg));
        z4_reg  <= z3_reg;
        // about y
        pa5_reg <= PW'(cos_reg) * PW'(x4_reg);
        pb5_reg <= PW'(sin_reg) * PW'(z4_reg);
        y5_reg  <= y4_reg;
        x6_reg  <= rnd(SW'(pa5_reg) + SW'(pb5_reg));
        y6_reg  <= y5_reg;
        // offset, truncate and saturate
        screen_x <= trunc_sat(OW'(x6_reg) + off_q8);
        screen_y <= trunc_sat(OW'(y6_reg) + off_q8);
    end

    assign done = valid_reg[LATENCY-1];

    // checks
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result beat without a vertex beat");

    a_beat_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##8 done)
        else $error("vertex beat lost in pipeline");

    a_sin_sign: assert property (@(posedge clk) disable iff (!rst_n)
        ((angle_reg == $past(angle_reg)) && !angle_reg[ANGLE_BITS-1])
        |-> !sin_reg[TRIG_BITS-1])
        else $error("sine negative in upper half plane");

    a_cos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        ((angle_reg == $past(angle_reg))
         && (angle_reg[ANGLE_BITS-1] == angle_reg[ANGLE_BITS-2]))
        |-> !cos_reg[TRIG_BITS-1])
        else $error("cosine negative in right half plane");

endmodule

`default_nettype wire
